### hw/rtl/tsp_pkg.sv
// Shared types, codes and texel arithmetic for the three-point texture sampler.
package tsp_pkg;

  // Request modes
  localparam logic [1:0] MODE_TEXEL   = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_SAMPLE  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_FORMAT  = 3'd3;
  localparam logic [2:0] CFG_FILTER  = 3'd4;
  localparam logic [2:0] CFG_WRAP_S  = 3'd5;
  localparam logic [2:0] CFG_WRAP_T  = 3'd6;

  // Wrap modes; the unused code behaves as repeat
  localparam logic [1:0] AXIS_REPEAT = 2'd0;
  localparam logic [1:0] AXIS_MIRROR = 2'd1;
  localparam logic [1:0] AXIS_CLAMP  = 2'd2;

  typedef enum logic [3:0] {
    FMT_565  = 4'd0,
    FMT_4444 = 4'd1,
    FMT_5551 = 4'd2,
    FMT_I8   = 4'd3,
    FMT_I4   = 4'd4,
    FMT_IA8  = 4'd5,
    FMT_IA4  = 4'd6,
    FMT_CI8  = 4'd7,
    FMT_CI4  = 4'd8
  } fmt_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // Byte and nibble pick within a fetched word
  typedef struct packed {
    logic byte_sel;
    logic nib_sel;
  } tap_sel_t;

  function automatic logic [7:0] grow5(input logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [7:0] grow4(input logic [3:0] x);
    return {x, x};
  endfunction

  function automatic rgba_t unpack_5551(input logic [15:0] p);
    rgba_t c;
    c.r = grow5(p[15:11]);
    c.g = grow5(p[10:6]);
    c.b = grow5(p[5:1]);
    c.a = p[0] ? 8'hff : 8'h00;
    return c;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [15:0] w, input tap_sel_t sel);
    return sel.byte_sel ? w[15:8] : w[7:0];
  endfunction

  // Odd column takes the low nibble
  function automatic logic [3:0] pick_nib(input logic [15:0] w, input tap_sel_t sel);
    logic [7:0] by;
    by = pick_byte(w, sel);
    return sel.nib_sel ? by[3:0] : by[7:4];
  endfunction

  // Direct-colour decode; palette formats are resolved elsewhere
  function automatic rgba_t decode_texel(input logic [3:0] fmt, input logic [15:0] w,
                                         input tap_sel_t sel);
    rgba_t      c;
    logic [7:0] by;
    logic [3:0] nb;
    logic [3:0] v;
    by = pick_byte(w, sel);
    nb = pick_nib(w, sel);
    v  = {nb[3:1], 1'b0};
    unique case (fmt)
      FMT_4444: begin
        c = '{grow4(w[15:12]), grow4(w[11:8]), grow4(w[7:4]), grow4(w[3:0])};
      end
      FMT_5551: c = unpack_5551(w);
      FMT_I8:   c = '{by, by, by, by};
      FMT_I4:   c = '{grow4(nb), grow4(nb), grow4(nb), grow4(nb)};
      FMT_IA8: begin
        c = '{{by[7:4], by[7:4]}, {by[7:4], by[7:4]}, {by[7:4], by[7:4]}, grow4(by[3:0])};
      end
      FMT_IA4: begin
        c.r = {v, 4'b0} | {3'b0, v, 1'b0} | {6'b0, v[3:2]};
        c.g = c.r;
        c.b = c.r;
        c.a = nb[0] ? 8'hff : 8'h00;
      end
      default: begin
        c = '{{w[15:11], w[15:13]}, {w[10:5], w[10:9]}, {w[4:0], w[4:2]}, 8'hff};
      end
    endcase
    return c;
  endfunction

  // Fold one integer coordinate onto a power-of-two axis
  function automatic logic [14:0] fold_axis(input logic signed [16:0] c, input logic [3:0] lg,
                                            input logic [1:0] wm);
    logic [15:0] top;
    logic [15:0] idx;
    logic [14:0] res;
    top = 16'((17'd1 << lg) - 17'd1);
    idx = c[15:0] & top;
    if (wm == AXIS_CLAMP) begin
      if (c[16])                       res = '0;
      else if (c > $signed({1'b0, top})) res = top[14:0];
      else                             res = c[14:0];
    end else if (wm == AXIS_MIRROR && c[lg]) begin
      res = 15'(top - idx);
    end else begin
      res = idx[14:0];
    end
    return res;
  endfunction

  // base + floor((ws*da + wt*db + 16) / 32), kept to 8 bits
  function automatic logic [7:0] blend3(input logic [7:0] base, input logic [5:0] ws,
                                        input logic signed [8:0] da, input logic [5:0] wt,
                                        input logic signed [8:0] db);
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [16:0] s;
    p1 = $signed({1'b0, ws}) * da;
    p2 = $signed({1'b0, wt}) * db;
    s  = {p1[15], p1} + {p2[15], p2} + 17'sd16;
    return base + s[12:5];
  endfunction

endpackage

### hw/rtl/tsp_if.sv
// Request and result channel interfaces of the texture sampler.
interface tsp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [10:0] address;
  logic [15:0] write_data;
  logic signed [31:0] coord_u;
  logic signed [31:0] coord_v;

  modport source (output valid, mode, address, write_data, coord_u, coord_v, input ready);
  modport sink   (input valid, mode, address, write_data, coord_u, coord_v, output ready);
endinterface

interface tsp_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] color_565;

  modport source (output valid, red, green, blue, alpha, color_565, input ready);
  modport sink   (input valid, red, green, blue, alpha, color_565, output ready);
endinterface

### hw/rtl/texture_sampler_three_point.sv
// Top level of the three-point texture sampler.
//
// Requests arrive on req: mode 0 writes a 16-bit word into the texel store,
// mode 1 writes a palette entry, mode 2 samples at signed Q16.16 (u,v);
// mode 3 is dropped. Only samples produce a result on res (RGBA8 plus a
// 5:6:5 pack). Registers are set through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle (not enforced).
// The texel store is held in four copies, one per tap, so all four taps of
// a 2x2 neighbourhood are read in the same cycle; palette lookups use the
// second stage. A new request can be taken every cycle while req.ready
// is high. From acceptance to result valid a sample goes through texel RAM
// read, decode plus palette read, and blend into the output register.
// Reset clears the configuration registers and empties the pipeline; store
// contents are undefined until written. When res is stalled, empty stages
// still fill, then req.ready drops until the output register frees.
module texture_sampler_three_point import tsp_pkg::*; #(
  parameter int TEX_WORDS       = 2048,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data,
  tsp_req_if.sink    req,
  tsp_res_if.source  res
);

  localparam int AW = $clog2(TEX_WORDS);
  localparam int PW = $clog2(PALETTE_ENTRIES);

  // Configuration registers
  logic       texture_enable, tri_filter;
  logic [3:0] width_log2, height_log2, texel_format;
  logic [1:0] wrap_mode_s, wrap_mode_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_enable <= 1'b0;
      width_log2     <= '0;
      height_log2    <= '0;
      texel_format   <= '0;
      tri_filter     <= 1'b0;
      wrap_mode_s    <= '0;
      wrap_mode_t    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ENABLE: texture_enable <= cfg_data[0];
        CFG_WIDTH:  width_log2     <= cfg_data;
        CFG_HEIGHT: height_log2    <= cfg_data;
        CFG_FORMAT: texel_format   <= cfg_data;
        CFG_FILTER: tri_filter     <= cfg_data[0];
        CFG_WRAP_S: wrap_mode_s    <= cfg_data[1:0];
        CFG_WRAP_T: wrap_mode_t    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Stage enables; a stage moves when it is empty or the next one moves
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic req_fire, is_ci;

  assign en3       = !v3 || res.ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req.ready = en1;
  assign req_fire  = req.valid && en1;
  assign is_ci     = texel_format == FMT_CI8 || texel_format == FMT_CI4;

  // Tap addresses
  logic [AW-1:0] word_addr [4];
  tap_sel_t      sel0 [4];
  logic [AW+10:0] waddr_ext;

  assign waddr_ext = (AW+11)'(req.address);

  tsp_addr_gen #(.AW(AW)) u_addr (
    .coord_u      (req.coord_u),
    .coord_v      (req.coord_v),
    .width_log2   (width_log2),
    .height_log2  (height_log2),
    .texel_format (texel_format),
    .wrap_mode_s  (wrap_mode_s),
    .wrap_mode_t  (wrap_mode_t),
    .word_addr    (word_addr),
    .sel          (sel0)
  );

  // Texel store, one copy per tap
  logic [15:0] tap_word [4];

  for (genvar k = 0; k < 4; k++) begin : g_bank
    tsp_ram #(.DEPTH(TEX_WORDS), .AW(AW)) u_texel (
      .clk   (clk),
      .we    (req_fire && req.mode == MODE_TEXEL),
      .waddr (waddr_ext[AW-1:0]),
      .wdata (req.write_data),
      .re    (en1),
      .raddr (word_addr[k]),
      .rdata (tap_word[k])
    );
  end

  // Stage 1: per-sample control alongside the RAM read
  logic        s1_zero, s1_ci, s1_filt, s1_upper;
  logic [3:0]  s1_fmt;
  logic [4:0]  s1_sf, s1_tf;
  tap_sel_t    s1_sel [4];
  logic [5:0]  frac_sum;

  assign frac_sum = {1'b0, req.coord_u[15:11]} + {1'b0, req.coord_v[15:11]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req_fire && req.mode == MODE_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_zero  <= !texture_enable;
      s1_ci    <= is_ci;
      s1_filt  <= tri_filter && !is_ci;
      s1_fmt   <= texel_format;
      s1_sf    <= req.coord_u[15:11];
      s1_tf    <= req.coord_v[15:11];
      s1_upper <= frac_sum[5];
      s1_sel   <= sel0;
    end
  end

  // Palette lookup from the first tap
  logic [7:0]    pal_byte;
  logic [3:0]    pal_nib;
  logic [7:0]    pal_idx;
  logic [15:0]   pal_word;

  assign pal_byte = pick_byte(tap_word[0], s1_sel[0]);
  assign pal_nib  = pick_nib(tap_word[0], s1_sel[0]);
  assign pal_idx  = (s1_fmt == FMT_CI8) ? pal_byte : {4'b0, pal_nib};

  tsp_ram #(.DEPTH(PALETTE_ENTRIES), .AW(PW)) u_palette (
    .clk   (clk),
    .we    (req_fire && req.mode == MODE_PALETTE),
    .waddr (req.address[PW-1:0]),
    .wdata (req.write_data),
    .re    (en2),
    .raddr (pal_idx[PW-1:0]),
    .rdata (pal_word)
  );

  // Stage 2: decoded taps
  rgba_t      s2_tap [4];
  logic       s2_zero, s2_ci, s2_filt, s2_upper;
  logic [4:0] s2_sf, s2_tf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 4; k++) begin
        s2_tap[k] <= decode_texel(s1_fmt, tap_word[k], s1_sel[k]);
      end
      s2_zero  <= s1_zero;
      s2_ci    <= s1_ci;
      s2_filt  <= s1_filt;
      s2_upper <= s1_upper;
      s2_sf    <= s1_sf;
      s2_tf    <= s1_tf;
    end
  end

  // Blend selection: lower triangle anchors on tap 0, upper on tap 3
  rgba_t      pal_rgba, blended, result_next;
  logic [7:0] a_ch [4];
  logic [7:0] b_ch [4];
  logic [7:0] d_ch [4];
  logic [7:0] e_ch [4];
  logic [7:0] bl_ch [4];
  logic [5:0] ws, wt;

  assign pal_rgba = unpack_5551(pal_word);
  assign ws = s2_upper ? 6'(6'd32 - {1'b0, s2_sf}) : {1'b0, s2_sf};
  assign wt = s2_upper ? 6'(6'd32 - {1'b0, s2_tf}) : {1'b0, s2_tf};

  always_comb begin
    a_ch = '{s2_tap[0].r, s2_tap[0].g, s2_tap[0].b, s2_tap[0].a};
    b_ch = '{s2_tap[1].r, s2_tap[1].g, s2_tap[1].b, s2_tap[1].a};
    d_ch = '{s2_tap[2].r, s2_tap[2].g, s2_tap[2].b, s2_tap[2].a};
    e_ch = '{s2_tap[3].r, s2_tap[3].g, s2_tap[3].b, s2_tap[3].a};
    for (int k = 0; k < 4; k++) begin
      if (s2_upper) begin
        bl_ch[k] = blend3(e_ch[k], ws, $signed({1'b0, d_ch[k]}) - $signed({1'b0, e_ch[k]}),
                          wt, $signed({1'b0, b_ch[k]}) - $signed({1'b0, e_ch[k]}));
      end else begin
        bl_ch[k] = blend3(a_ch[k], ws, $signed({1'b0, b_ch[k]}) - $signed({1'b0, a_ch[k]}),
                          wt, $signed({1'b0, d_ch[k]}) - $signed({1'b0, a_ch[k]}));
      end
    end
    blended = '{bl_ch[0], bl_ch[1], bl_ch[2], bl_ch[3]};
    priority if (s2_zero) begin
      result_next = '0;
    end else if (s2_ci) begin
      result_next = pal_rgba;
    end else if (s2_filt) begin
      result_next = blended;
    end else begin
      result_next = s2_tap[0];
    end
  end

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      res.red       <= result_next.r;
      res.green     <= result_next.g;
      res.blue      <= result_next.b;
      res.alpha     <= result_next.a;
      res.color_565 <= {result_next.r[7:3], result_next.g[7:2], result_next.b[7:3]};
    end
  end

  assign res.valid = v3;

endmodule

### hw/rtl/tsp_ram.sv
// Single-write, single-read synchronous RAM with registered read data.
module tsp_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tsp_addr_gen.sv
// Tap address generation: floor, wrap and linearise the four 2x2 taps.
module tsp_addr_gen import tsp_pkg::*; #(
  parameter int AW = 11
) (
  input  logic signed [31:0] coord_u,
  input  logic signed [31:0] coord_v,
  input  logic [3:0]         width_log2,
  input  logic [3:0]         height_log2,
  input  logic [3:0]         texel_format,
  input  logic [1:0]         wrap_mode_s,
  input  logic [1:0]         wrap_mode_t,
  output logic [AW-1:0]      word_addr [4],
  output tap_sel_t           sel [4]
);

  logic signed [16:0] s0, s1, t0, t1;
  logic [14:0] col [2];
  logic [14:0] row [2];
  logic [31:0] lin [4];
  logic [31:0] word [4];
  logic        is8, is4;

  assign s0 = {coord_u[31], coord_u[31:16]};
  assign t0 = {coord_v[31], coord_v[31:16]};
  assign s1 = s0 + 17'sd1;
  assign t1 = t0 + 17'sd1;

  assign col[0] = fold_axis(s0, width_log2, wrap_mode_s);
  assign col[1] = fold_axis(s1, width_log2, wrap_mode_s);
  assign row[0] = fold_axis(t0, height_log2, wrap_mode_t);
  assign row[1] = fold_axis(t1, height_log2, wrap_mode_t);

  assign is8 = texel_format == FMT_I8 || texel_format == FMT_IA8 || texel_format == FMT_CI8;
  assign is4 = texel_format == FMT_I4 || texel_format == FMT_IA4 || texel_format == FMT_CI4;

  // Tap order: (s,t), (s+1,t), (s,t+1), (s+1,t+1)
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lin[k]  = ({17'b0, row[k/2]} << width_log2) + {17'b0, col[k%2]};
      word[k] = is4 ? (lin[k] >> 2) : (is8 ? (lin[k] >> 1) : lin[k]);
      word_addr[k]    = word[k][AW-1:0];
      sel[k].byte_sel = is4 ? lin[k][1] : lin[k][0];
      sel[k].nib_sel  = col[k%2][0];
    end
  end

endmodule

### hw/rtl/tsp_checker.sv
// Port-level assertions for the texture sampler, bound to the top level.
module tsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [7:0]  alpha,
  input logic [15:0] color_565
);

  // A stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable({red, green, blue, alpha, color_565}))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // The packed colour agrees with the channels of every valid result
  a_pack: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> color_565 == {red[7:3], green[7:2], blue[7:3]})
    else $error("color_565 mismatch");

  // With the output free the pipeline must take requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("request refused with empty output");

endmodule

bind texture_sampler_three_point tsp_checker u_tsp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .red       (res.red),
  .green     (res.green),
  .blue      (res.blue),
  .alpha     (res.alpha),
  .color_565 (res.color_565)
);
